/* sv/asu_pkg.sv */
// types, constants and helper functions for the adam / sgd parameter update
// no dependencies; used by every module of the block
package asu_pkg;

	localparam int SQ_STEPS  = 29;
	localparam int DIV_STEPS = 58;

	localparam logic [2:0] REG_USE_ADAM   = 3'd0;
	localparam logic [2:0] REG_RATE       = 3'd1;
	localparam logic [2:0] REG_DECAY1     = 3'd2;
	localparam logic [2:0] REG_DECAY2     = 3'd3;
	localparam logic [2:0] REG_CORR1      = 3'd4;
	localparam logic [2:0] REG_CORR2      = 3'd5;
	localparam logic [2:0] REG_EPSILON    = 3'd6;

	localparam logic        RST_USE_ADAM = 1'b1;
	localparam logic [15:0] RST_RATE     = 16'd66;
	localparam logic [15:0] RST_DECAY1   = 16'd58982;
	localparam logic [15:0] RST_DECAY2   = 16'd65470;
	localparam logic [25:0] RST_CORR1    = 26'd655360;
	localparam logic [25:0] RST_CORR2    = 26'd65536000;
	localparam logic [15:0] RST_EPSILON  = 16'd1;

	typedef struct packed {
		logic        use_adam;
		logic [15:0] rate;
		logic [15:0] decay1;
		logic [15:0] decay2;
		logic [25:0] corr1;
		logic [25:0] corr2;
		logic [15:0] eps;
	} cfg_t;

	// values that ride along with an item down the pipe
	typedef struct packed {
		logic        adam;
		logic [31:0] w;
		logic [31:0] wd;
		logic [31:0] mo;
		logic [31:0] vo;
		logic        neg;
		logic [57:0] num;
	} pay_t;

	typedef struct packed {
		pay_t        p;
		logic [57:0] x;
		logic [30:0] rem;
		logic [28:0] root;
	} sq_t;

	typedef struct packed {
		pay_t        p;
		logic [57:0] n;
		logic [29:0] den;
		logic [29:0] rem;
		logic [57:0] q;
	} dv_t;

	// divide by 2^16, round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] p);
		logic [63:0] mag;
		logic [63:0] r;
		mag = p[63] ? (~p + 64'd1) : p;
		r   = (mag + 64'h8000) >> 16;
		return p[63] ? $signed(~r + 64'd1) : $signed(r);
	endfunction

	function automatic logic [31:0] sat_s32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'h7fff_ffff;
		else if (x < -64'sd2147483648)
			return 32'h8000_0000;
		else
			return x[31:0];
	endfunction

endpackage

/* sv/asu_front.sv */
// front arithmetic: moments, bias correction, numerator and sqrt operand (six stages)
// depends on asu_pkg
module asu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  asu_pkg::cfg_t       cfg,
	input  logic                vld_in,
	input  logic signed [31:0]  weight,
	input  logic signed [31:0]  gradient,
	input  logic signed [31:0]  first_moment,
	input  logic        [31:0]  second_moment,
	output logic                vld_out,
	output asu_pkg::sq_t        dout
);

	logic [5:0] vld_q;

	// stage 1: products
	logic               adam_s1;
	logic [31:0]        w_s1, m_s1, v_s1;
	logic signed [48:0] pm_s1;
	logic signed [49:0] pg_s1;
	logic [63:0]        gsq_s1;
	logic signed [48:0] pd_s1;
	// stage 2
	logic               adam_s2;
	logic [31:0]        w_s2, wd_s2, mo_s2, v_s2, mn_s2;
	logic [46:0]        g2_s2;
	// stage 3
	logic               adam_s3;
	logic [31:0]        w_s3, wd_s3, mo_s3, v_s3;
	logic [47:0]        pv1_s3;
	logic [63:0]        pv2_s3;
	logic signed [58:0] mhp_s3;
	// stage 4
	logic               adam_s4;
	logic [31:0]        w_s4, wd_s4, mo_s4, vo_s4, vn_s4;
	logic signed [42:0] mh_s4;
	// stage 5
	logic               adam_s5, neg_s5;
	logic [31:0]        w_s5, wd_s5, mo_s5, vo_s5;
	logic [57:0]        vhp_s5, num_s5;
	// stage 6
	logic               adam_s6, neg_s6;
	logic [31:0]        w_s6, wd_s6, mo_s6, vo_s6;
	logic [57:0]        num_s6;
	logic [41:0]        vh_s6;

	logic [31:0]        gmag;
	logic [16:0]        c1, c2;
	logic signed [63:0] msum;
	logic [31:0]        mn;
	logic [63:0]        gsq_rnd;
	logic [63:0]        vsum;
	logic signed [63:0] mh_full;
	logic [41:0]        mh_mag;
	logic [57:0]        vh_rnd;

	always_comb begin
		gmag    = gradient[31] ? (~gradient + 32'd1) : gradient;
		c1      = 17'h10000 - {1'b0, cfg.decay1};
		c2      = 17'h10000 - {1'b0, cfg.decay2};
		msum    = 64'(pm_s1) + 64'(pg_s1);
		mn      = asu_pkg::sat_s32(asu_pkg::rnd_q16(msum));
		gsq_rnd = gsq_s1 + 64'h8000;
		vsum    = 64'(pv1_s3) + pv2_s3 + 64'h8000;
		mh_full = asu_pkg::rnd_q16(64'(mhp_s3));
		mh_mag  = mh_s4[42] ? 42'(-mh_s4) : 42'(mh_s4);
		vh_rnd  = vhp_s5 + 58'h8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adam_s1 <= cfg.use_adam;
			w_s1    <= weight;
			m_s1    <= first_moment;
			v_s1    <= second_moment;
			pm_s1   <= first_moment * $signed({1'b0, cfg.decay1});
			pg_s1   <= gradient * $signed({1'b0, c1});
			gsq_s1  <= gmag * gmag;
			pd_s1   <= gradient * $signed({1'b0, cfg.rate});

			adam_s2 <= adam_s1;
			w_s2    <= w_s1;
			v_s2    <= v_s1;
			mn_s2   <= mn;
			mo_s2   <= adam_s1 ? mn : m_s1;
			g2_s2   <= gsq_rnd[62:16];
			wd_s2   <= asu_pkg::sat_s32(64'($signed(w_s1)) - asu_pkg::rnd_q16(64'(pd_s1)));

			adam_s3 <= adam_s2;
			w_s3    <= w_s2;
			wd_s3   <= wd_s2;
			mo_s3   <= mo_s2;
			v_s3    <= v_s2;
			pv1_s3  <= cfg.decay2 * v_s2;
			pv2_s3  <= c2 * g2_s2;
			mhp_s3  <= $signed(mn_s2) * $signed({1'b0, cfg.corr1});

			adam_s4 <= adam_s3;
			w_s4    <= w_s3;
			wd_s4   <= wd_s3;
			mo_s4   <= mo_s3;
			vn_s4   <= (|vsum[63:48]) ? 32'hffff_ffff : vsum[47:16];
			vo_s4   <= adam_s3 ? ((|vsum[63:48]) ? 32'hffff_ffff : vsum[47:16]) : v_s3;
			mh_s4   <= mh_full[42:0];

			adam_s5 <= adam_s4;
			w_s5    <= w_s4;
			wd_s5   <= wd_s4;
			mo_s5   <= mo_s4;
			vo_s5   <= vo_s4;
			vhp_s5  <= vn_s4 * cfg.corr2;
			num_s5  <= mh_mag * cfg.rate;
			neg_s5  <= mh_s4[42];

			adam_s6 <= adam_s5;
			w_s6    <= w_s5;
			wd_s6   <= wd_s5;
			mo_s6   <= mo_s5;
			vo_s6   <= vo_s5;
			num_s6  <= num_s5;
			neg_s6  <= neg_s5;
			vh_s6   <= vh_rnd[57:16];
		end
	end

	assign vld_out      = vld_q[5];
	assign dout.p.adam  = adam_s6;
	assign dout.p.w     = w_s6;
	assign dout.p.wd    = wd_s6;
	assign dout.p.mo    = mo_s6;
	assign dout.p.vo    = vo_s6;
	assign dout.p.neg   = neg_s6;
	assign dout.p.num   = num_s6;
	assign dout.x       = {vh_s6, 16'h0000};
	assign dout.rem     = '0;
	assign dout.root    = '0;

endmodule

/* sv/asu_sqrt_step.sv */
// one registered step of the bit-pair square root, one root bit per stage
// depends on asu_pkg
module asu_sqrt_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  asu_pkg::sq_t din,
	output logic         vld_out,
	output asu_pkg::sq_t dout
);

	logic         vld_q;
	asu_pkg::sq_t dat_q;
	asu_pkg::sq_t nxt;
	logic [32:0]  sh;
	logic [32:0]  trial;

	always_comb begin
		nxt   = din;
		sh    = {din.rem, din.x[57:56]};
		trial = {2'b00, din.root, 2'b01};
		nxt.x = {din.x[55:0], 2'b00};
		if (sh >= trial) begin
			nxt.rem  = 31'(sh - trial);
			nxt.root = {din.root[27:0], 1'b1};
		end else begin
			nxt.rem  = sh[30:0];
			nxt.root = {din.root[27:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign dout    = dat_q;

endmodule

/* sv/asu_div_step.sv */
// one registered step of the restoring divider, one quotient bit per stage
// depends on asu_pkg
module asu_div_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  asu_pkg::dv_t din,
	output logic         vld_out,
	output asu_pkg::dv_t dout
);

	logic         vld_q;
	asu_pkg::dv_t dat_q;
	asu_pkg::dv_t nxt;
	logic [30:0]  sh;

	always_comb begin
		nxt   = din;
		sh    = {din.rem, din.n[57]};
		nxt.n = {din.n[56:0], 1'b0};
		if (sh >= {1'b0, din.den}) begin
			nxt.rem = 30'(sh - {1'b0, din.den});
			nxt.q   = {din.q[56:0], 1'b1};
		end else begin
			nxt.rem = sh[29:0];
			nxt.q   = {din.q[56:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign dout    = dat_q;

endmodule

/* sv/adam_sgd_parameter_update.sv */
// adam / plain sgd parameter update, top level
// pipeline from accepted input transaction to output: 6 front stages,
// 29 square root stages, 1 denominator stage, 58 divider stages, 1 output register
// throughput: one transaction per cycle; the whole pipe advances unless the output is stalled
// reset: arst_n clears all valid bits and loads the registers with their defaults
// depends on asu_pkg, asu_front, asu_sqrt_step, asu_div_step
module adam_sgd_parameter_update (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [25:0]        wr_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] weight,
	input  logic signed [31:0] gradient,
	input  logic signed [31:0] first_moment,
	input  logic        [31:0] second_moment,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_weight,
	output logic signed [31:0] new_first_moment,
	output logic        [31:0] new_second_moment
);

	asu_pkg::cfg_t cfg_q;

	// global advance: every stage moves unless a finished result is held
	logic en;

	logic          front_vld;
	asu_pkg::sq_t  front_dat;

	logic          sq_vld [0:asu_pkg::SQ_STEPS];
	asu_pkg::sq_t  sq_dat [0:asu_pkg::SQ_STEPS];

	logic          dv_vld [0:asu_pkg::DIV_STEPS];
	asu_pkg::dv_t  dv_dat [0:asu_pkg::DIV_STEPS];

	logic          den_vld_q;
	asu_pkg::dv_t  den_dat_q;
	logic [29:0]   den_raw;
	logic [29:0]   den;

	logic          out_vld_q;
	logic [31:0]   nw_q, nm_q, nv_q;
	logic signed [63:0] wsum;
	logic [31:0]   nw;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_adam <= asu_pkg::RST_USE_ADAM;
			cfg_q.rate     <= asu_pkg::RST_RATE;
			cfg_q.decay1   <= asu_pkg::RST_DECAY1;
			cfg_q.decay2   <= asu_pkg::RST_DECAY2;
			cfg_q.corr1    <= asu_pkg::RST_CORR1;
			cfg_q.corr2    <= asu_pkg::RST_CORR2;
			cfg_q.eps      <= asu_pkg::RST_EPSILON;
		end else if (wr_en) begin
			unique case (wr_index)
				asu_pkg::REG_USE_ADAM: cfg_q.use_adam <= wr_data[0];
				asu_pkg::REG_RATE:     cfg_q.rate     <= wr_data[15:0];
				asu_pkg::REG_DECAY1:   cfg_q.decay1   <= wr_data[15:0];
				asu_pkg::REG_DECAY2:   cfg_q.decay2   <= wr_data[15:0];
				asu_pkg::REG_CORR1:    cfg_q.corr1    <= wr_data;
				asu_pkg::REG_CORR2:    cfg_q.corr2    <= wr_data;
				asu_pkg::REG_EPSILON:  cfg_q.eps      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	// moments, bias correction, numerator, sqrt operand
	asu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.cfg           (cfg_q),
		.vld_in        (in_valid && !in_stall),
		.weight        (weight),
		.gradient      (gradient),
		.first_moment  (first_moment),
		.second_moment (second_moment),
		.vld_out       (front_vld),
		.dout          (front_dat)
	);

	assign sq_vld[0] = front_vld;
	assign sq_dat[0] = front_dat;

	// floor square root of vh * 2^16, one root bit per stage
	for (genvar i = 0; i < asu_pkg::SQ_STEPS; i++) begin : g_sqrt
		asu_sqrt_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (sq_vld[i]),
			.din     (sq_dat[i]),
			.vld_out (sq_vld[i+1]),
			.dout    (sq_dat[i+1])
		);
	end

	// denominator = root + eps, zero forced to one lsb; rounding half added to numerator
	always_comb begin
		den_raw = 30'(sq_dat[asu_pkg::SQ_STEPS].root) + 30'(cfg_q.eps);
		den     = (den_raw == '0) ? 30'd1 : den_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_vld_q <= 1'b0;
		end else if (en) begin
			den_vld_q <= sq_vld[asu_pkg::SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_dat_q.p   <= sq_dat[asu_pkg::SQ_STEPS].p;
			den_dat_q.n   <= sq_dat[asu_pkg::SQ_STEPS].p.num + 58'(den >> 1);
			den_dat_q.den <= den;
			den_dat_q.rem <= '0;
			den_dat_q.q   <= '0;
		end
	end

	assign dv_vld[0] = den_vld_q;
	assign dv_dat[0] = den_dat_q;

	// step = numerator / denominator, one quotient bit per stage
	for (genvar j = 0; j < asu_pkg::DIV_STEPS; j++) begin : g_div
		asu_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (dv_vld[j]),
			.din     (dv_dat[j]),
			.vld_out (dv_vld[j+1]),
			.dout    (dv_dat[j+1])
		);
	end

	// apply the step with the sign of the corrected first moment
	always_comb begin
		if (dv_dat[asu_pkg::DIV_STEPS].p.neg)
			wsum = 64'($signed(dv_dat[asu_pkg::DIV_STEPS].p.w))
				+ 64'(dv_dat[asu_pkg::DIV_STEPS].q);
		else
			wsum = 64'($signed(dv_dat[asu_pkg::DIV_STEPS].p.w))
				- 64'(dv_dat[asu_pkg::DIV_STEPS].q);
		nw = dv_dat[asu_pkg::DIV_STEPS].p.adam ? asu_pkg::sat_s32(wsum)
			: dv_dat[asu_pkg::DIV_STEPS].p.wd;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[asu_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nw_q <= nw;
			nm_q <= dv_dat[asu_pkg::DIV_STEPS].p.mo;
			nv_q <= dv_dat[asu_pkg::DIV_STEPS].p.vo;
		end
	end

	assign out_valid         = out_vld_q;
	assign new_weight        = nw_q;
	assign new_first_moment  = nm_q;
	assign new_second_moment = nv_q;

endmodule

/* verif/tb_top.sv */
// self-checking testbench for adam_sgd_parameter_update
// drives parameter elements, predicts each update and compares field by field
// depends on asu_pkg and adam_sgd_parameter_update
`timescale 1ns / 100ps

module tb_top;

	localparam int LATENCY   = 95;
	localparam int CYC_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] w;
		logic [31:0] g;
		logic [31:0] m;
		logic [31:0] v;
	} elem_t;

	typedef struct packed {
		logic [31:0] nw;
		logic [31:0] nm;
		logic [31:0] nv;
	} upd_t;

	// one row of the directed table: optional config write, element, optional typed result
	typedef struct {
		bit          do_wr;
		logic [2:0]  idx;
		logic [25:0] val;
		elem_t       e;
		bit          has_exp;
		upd_t        x;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [2:0]         wr_index;
	logic [25:0]        wr_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] weight;
	logic signed [31:0] gradient;
	logic signed [31:0] first_moment;
	logic        [31:0] second_moment;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] new_weight;
	logic signed [31:0] new_first_moment;
	logic        [31:0] new_second_moment;

	// predictor copy of the registers
	logic        p_adam;
	logic [15:0] p_rate, p_d1, p_d2, p_eps;
	logic [25:0] p_c1, p_c2;

	upd_t expected_updates[$];
	int   mismatches;
	int   cycles;
	int   send_idle_pct, recv_idle_pct;

	adam_sgd_parameter_update i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.weight           (weight),
		.gradient         (gradient),
		.first_moment     (first_moment),
		.second_moment    (second_moment),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.new_weight       (new_weight),
		.new_first_moment (new_first_moment),
		.new_second_moment(new_second_moment)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint q16_round(longint p);
		longint unsigned mag;
		mag = p < 0 ? -p : p;
		mag = (mag + 64'h8000) >> 16;
		return p < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clip_s32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void shadow_write(logic [2:0] idx, logic [25:0] val);
		case (idx)
			asu_pkg::REG_USE_ADAM: p_adam = val[0];
			asu_pkg::REG_RATE:     p_rate = val[15:0];
			asu_pkg::REG_DECAY1:   p_d1   = val[15:0];
			asu_pkg::REG_DECAY2:   p_d2   = val[15:0];
			asu_pkg::REG_CORR1:    p_c1   = val;
			asu_pkg::REG_CORR2:    p_c2   = val;
			asu_pkg::REG_EPSILON:  p_eps  = val[15:0];
			default:      ;
		endcase
	endfunction

	// computes the updated weight and moments for one element
	function automatic upd_t compute_update(elem_t e);
		upd_t r;
		longint w, g, m, nw, c1, mn, mh;
		longint unsigned v, c2, gm, g2, vn, vh, den, step, mag;
		w = longint'($signed(e.w));
		g = longint'($signed(e.g));
		m = longint'($signed(e.m));
		v = {32'd0, e.v};
		if (!p_adam) begin
			nw = clip_s32(w - q16_round(g * longint'({48'd0, p_rate})));
			r.nw = nw[31:0];
			r.nm = e.m;
			r.nv = e.v;
			return r;
		end
		c1 = 65536 - longint'({48'd0, p_d1});
		c2 = 65536 - {48'd0, p_d2};
		gm = g < 0 ? -g : g;
		g2 = (gm * gm + 64'h8000) >> 16;
		mn = clip_s32(q16_round(m * longint'({48'd0, p_d1}) + g * c1));
		vn = ({48'd0, p_d2} * v + c2 * g2 + 64'h8000) >> 16;
		if (vn > 64'hffff_ffff)
			vn = 64'hffff_ffff;
		mh = q16_round(mn * longint'({38'd0, p_c1}));
		vh = (vn * {38'd0, p_c2} + 64'h8000) >> 16;
		den = int_sqrt(vh << 16) + {48'd0, p_eps};
		if (den == 0)
			den = 1;
		mag = mh < 0 ? -mh : mh;
		step = (mag * {48'd0, p_rate} + (den >> 1)) / den;
		nw = mh < 0 ? clip_s32(w + longint'(step)) : clip_s32(w - longint'(step));
		r.nw = nw[31:0];
		r.nm = mn[31:0];
		r.nv = vn[31:0];
		return r;
	endfunction

	// register write while idle, at the falling edge
	task automatic write_reg(logic [2:0] idx, logic [25:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		shadow_write(idx, val);
	endtask

	// waits for all results, then lets the pipe drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_updates.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	// sends one transaction; optionally an explicit expected result replaces the prediction
	task automatic send_elem(elem_t e, bit has_exp, upd_t x);
		upd_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		weight        <= e.w;
		gradient      <= e.g;
		first_moment  <= e.m;
		second_moment <= e.v;
		in_valid      <= 1'b1;
		pred = compute_update(e);
		if (has_exp && pred != x)
			$display("note: typed row differs from predictor w=%h", e.w);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_updates.push_back(has_exp ? x : pred);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(131072) - 65536;
			3: return $urandom_range(16777215);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n, int sidle, int ridle);
		elem_t e;
		upd_t none;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		none = '{default: '0};
		for (int i = 0; i < n; i++) begin
			e.w = rand_field();
			e.g = rand_field();
			e.m = rand_field();
			e.v = rand_field();
			send_elem(e, 1'b0, none);
			// pause until the pipe is empty once per phase
			if (i == n / 2) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (expected_updates.size() != 0)
					@(negedge clk);
			end
		end
		wait_idle();
	endtask

	task automatic random_config(bit extreme);
		write_reg(asu_pkg::REG_USE_ADAM, 26'($urandom_range(1)));
		write_reg(asu_pkg::REG_RATE, extreme ? 26'hffff : 26'($urandom_range(65535)));
		write_reg(asu_pkg::REG_DECAY1, extreme ? 26'd0 : 26'($urandom_range(65535)));
		write_reg(asu_pkg::REG_DECAY2, extreme ? 26'hffff : 26'($urandom_range(65535)));
		write_reg(asu_pkg::REG_CORR1,
			extreme ? 26'h3ff_ffff : 26'($urandom_range(67108863, 65536)));
		write_reg(asu_pkg::REG_CORR2, extreme ? 26'd0 : 26'($urandom));
		write_reg(asu_pkg::REG_EPSILON, extreme ? 26'd0 : 26'($urandom_range(65535)));
	endtask

	// receiver: random stall at the falling edge and result check at the rising edge
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		upd_t exp_u;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected transaction w=%h", new_weight);
			end else begin
				exp_u = expected_updates.pop_front();
				if (new_weight !== exp_u.nw || new_first_moment !== exp_u.nm ||
				    new_second_moment !== exp_u.nv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: exp w=%h m=%h v=%h got w=%h m=%h v=%h",
							exp_u.nw, exp_u.nm, exp_u.nv,
							new_weight, new_first_moment, new_second_moment);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		row_t  rows[$];
		row_t  r;
		upd_t  none;
		none = '{default: '0};
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		weight = '0;
		gradient = '0;
		first_moment = '0;
		second_moment = '0;
		p_adam = asu_pkg::RST_USE_ADAM;
		p_rate = asu_pkg::RST_RATE;
		p_d1 = asu_pkg::RST_DECAY1;
		p_d2 = asu_pkg::RST_DECAY2;
		p_c1 = asu_pkg::RST_CORR1;
		p_c2 = asu_pkg::RST_CORR2;
		p_eps = asu_pkg::RST_EPSILON;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table; all-zero element after reset gives all-zero result
		rows.push_back('{1'b0, asu_pkg::REG_USE_ADAM, 26'd0, '{0, 0, 0, 0}, 1'b1, '{0, 0, 0}});
		rows.push_back('{1'b0, asu_pkg::REG_USE_ADAM, 26'd0,
			'{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff}, 1'b0, none});
		rows.push_back('{1'b0, asu_pkg::REG_USE_ADAM, 26'd0,
			'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff}, 1'b0, none});
		// zero denominator: no second moment, no epsilon
		rows.push_back('{1'b1, asu_pkg::REG_EPSILON, 26'd0,
			'{32'h10000, 0, 32'h10000, 0}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_DECAY1, 26'd0,
			'{0, 32'h20000, 32'h5000, 32'h3000}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_DECAY1, 26'hffff,
			'{0, 32'h20000, 32'h5000, 0}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_DECAY2, 26'd0,
			'{0, 32'hfffe0000, 32'h5000, 32'h9000}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_DECAY2, 26'hffff,
			'{0, 32'h7fff_ffff, 0, 32'hffff_ffff}, 1'b0, none});
		// corrections of zero and below one, and the largest second correction
		rows.push_back('{1'b1, asu_pkg::REG_CORR1, 26'd0,
			'{32'h1234, 32'h40000, 32'h40000, 32'h100}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_CORR1, 26'h8000,
			'{32'h1234, 32'h40000, 32'h40000, 32'h100}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_CORR2, 26'd0,
			'{32'h1234, 32'h40000, 32'h40000, 32'h100}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_CORR2, 26'h3ff_ffff,
			'{32'h1234, 32'h40000, 32'h40000, 32'h100}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_RATE, 26'hffff,
			'{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0}, 1'b0, none});
		rows.push_back('{1'b1, asu_pkg::REG_EPSILON, 26'hffff,
			'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0}, 1'b0, none});
		// descent mode: moments pass, weight saturates
		rows.push_back('{1'b1, asu_pkg::REG_USE_ADAM, 26'd1,
			'{32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'hdead_beef},
			1'b1, '{32'h7fff_ffff, 32'h1234_5678, 32'hdead_beef}});
		rows.push_back('{1'b0, asu_pkg::REG_USE_ADAM, 26'd0,
			'{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff},
			1'b1, '{32'h8000_0000, 32'h8000_0000, 32'hffff_ffff}});
		rows.push_back('{1'b0, asu_pkg::REG_USE_ADAM, 26'd0,
			'{32'h10000, 32'h10000, 0, 0}, 1'b0, none});
		// unused register index is ignored
		rows.push_back('{1'b1, 3'd7, 26'h3ff_ffff,
			'{32'h10000, 32'hffff0000, 5, 7}, 1'b0, none});
		foreach (rows[i]) begin
			r = rows[i];
			if (r.do_wr) begin
				wait_idle();
				// for the mode register a row value of one selects descent
				write_reg(r.idx, (r.idx == asu_pkg::REG_USE_ADAM) ? 26'(r.val == 0) : r.val);
			end
			send_elem(r.e, r.has_exp, r.x);
		end
		wait_idle();

		random_config(1'b1);
		random_phase(700, 17, 50);
		random_config(1'b0);
		random_phase(700, 50, 17);
		write_reg(asu_pkg::REG_USE_ADAM, 26'd1);
		random_phase(600, 0, 0);

		while (expected_updates.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (mismatches == 0 && expected_updates.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
sv/asu_pkg.sv
sv/asu_front.sv
sv/asu_sqrt_step.sv
sv/asu_div_step.sv
sv/adam_sgd_parameter_update.sv
verif/tb_top.sv
